>>> hw/rtl/ipsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsa_pkg: shared types and constants for the SA table with replay check
// Slot count, command and verdict codes, transaction structs and the
// store write/read structs used between the sequencer and the slot store.
// ----------------------------------------------------------------------------
package ipsa_pkg;

  localparam int SaEntries = 16;
  localparam int SlotW     = (SaEntries > 1) ? $clog2(SaEntries) : 1;

  typedef logic [SlotW-1:0] slot_t;

  localparam slot_t LastSlot = SlotW'(SaEntries - 1);

  localparam logic [1:0] ModeCheck  = 2'd0;
  localparam logic [1:0] ModeAdd    = 2'd1;
  localparam logic [1:0] ModeRemove = 2'd2;

  localparam logic [2:0] VerdictOk        = 3'd0;
  localparam logic [2:0] VerdictShort     = 3'd1;
  localparam logic [2:0] VerdictMalformed = 3'd2;
  localparam logic [2:0] VerdictReplay    = 3'd3;
  localparam logic [2:0] VerdictFull      = 3'd4;

  localparam logic [15:0] EspMinLen = 16'd8;
  localparam logic [15:0] AhMinLen  = 16'd12;
  localparam logic [10:0] AhMinSize = 11'd12;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] peer_address;
    logic [31:0] spi;
    logic [31:0] seq_number;
    logic        is_esp;
    logic [7:0]  length_words;
    logic [15:0] packet_length;
  } req_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic        learned;
    logic [10:0] inner_offset;
  } rsp_t;

  typedef struct packed {
    logic        key_we;
    logic        seq_we;
    logic        set_valid;
    logic        clr_valid;
    slot_t       addr;
    logic [31:0] peer;
    logic [31:0] spi;
    logic [31:0] seq;
  } slot_wr_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] peer;
    logic [31:0] spi;
    logic [31:0] seq;
  } slot_rd_t;

  typedef struct packed {
    logic spi_eq;
    logic pair_eq;
    logic replay;
  } cmp_t;

endpackage

>>> hw/rtl/ipsa_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsa_slot_store: security-association slot storage
// Valid bits in flops cleared by reset; peer, SPI and last sequence in
// memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ipsa_slot_store (
  input  logic               clk,
  input  logic               rst,
  input  ipsa_pkg::slot_wr_t wr,
  input  ipsa_pkg::slot_t    rd_addr,
  output ipsa_pkg::slot_rd_t rd
);

  logic [ipsa_pkg::SaEntries-1:0] slot_valid;
  logic [31:0] peer_mem [ipsa_pkg::SaEntries];
  logic [31:0] spi_mem  [ipsa_pkg::SaEntries];
  logic [31:0] seq_mem  [ipsa_pkg::SaEntries];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr.set_valid) begin
      slot_valid[wr.addr] <= 1'b1;
    end else if (wr.clr_valid) begin
      slot_valid[wr.addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      peer_mem[wr.addr] <= wr.peer;
      spi_mem[wr.addr]  <= wr.spi;
    end
    if (wr.seq_we) begin
      seq_mem[wr.addr] <= wr.seq;
    end
  end

  always_ff @(posedge clk) begin
    rd.valid <= slot_valid[rd_addr];
    rd.peer  <= peer_mem[rd_addr];
    rd.spi   <= spi_mem[rd_addr];
    rd.seq   <= seq_mem[rd_addr];
  end

endmodule

>>> hw/rtl/ipsa_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsa_match_unit: shared slot comparator
// Compares one read slot against the command key and checks the sequence
// number against the stored one for replay.
// ----------------------------------------------------------------------------
module ipsa_match_unit (
  input  ipsa_pkg::slot_rd_t rd,
  input  logic [31:0]        peer,
  input  logic [31:0]        spi,
  input  logic [31:0]        seq,
  output ipsa_pkg::cmp_t     cmp
);

  always_comb begin
    cmp.spi_eq  = rd.valid && (rd.spi == spi);
    cmp.pair_eq = cmp.spi_eq && (rd.peer == peer);
    cmp.replay  = (seq <= rd.seq) && (rd.seq != 32'd0);
  end

endmodule

>>> hw/rtl/ipsec_sa_table_replay_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsec_sa_table_replay_check_core: SA table with learning and replay check
// Sequencer that scans the slot store through one shared comparator.
// ----------------------------------------------------------------------------
// Commands arrive on req (req_valid/req_stall) and each gives one response on
// rsp (rsp_valid/rsp_stall). Mode 0 checks a packet header, mode 1 adds an
// entry, mode 2 removes the first entry with a matching SPI.
// A command that fails the length check, and mode 3, skip the slot walk and
// answer from the done state. Other commands walk the slots from slot 0,
// each slot read through the registered read port of the slot store and then
// compared in the shared match unit, stopping at the first hit, or for an add
// at the first free slot.
// One command is in work at a time: req_stall is high from acceptance until
// the response is loaded into the output register.
// The output register holds a response while rsp_stall is high; the next
// command is accepted meanwhile, and its response waits until the register
// is free.
// Reset clears all slot valid bits at once, with no clearing pass, and
// empties the output register.
// ----------------------------------------------------------------------------
module ipsec_sa_table_replay_check_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ipsa_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ipsa_pkg::rsp_t rsp
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StCmp  = 3'd2;
  localparam logic [2:0] StUpd  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]          state;
  ipsa_pkg::req_t      item;
  logic [10:0]         ah_size;
  ipsa_pkg::slot_t     ptr;
  ipsa_pkg::slot_t     free_slot;
  logic                free_found;
  logic                hit;
  ipsa_pkg::rsp_t      res;
  ipsa_pkg::rsp_t      upd_res;
  ipsa_pkg::rsp_t      start_res;
  ipsa_pkg::slot_wr_t  wr;
  ipsa_pkg::slot_rd_t  rd;
  ipsa_pkg::cmp_t      cmp;
  logic [10:0]         ah_in;
  logic                too_short;
  logic                malformed;
  logic                hit_now;
  logic [10:0]         pass_offset;

  ipsa_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (ptr),
    .rd      (rd)
  );

  ipsa_match_unit u_match (
    .rd   (rd),
    .peer (item.peer_address),
    .spi  (item.spi),
    .seq  (item.seq_number),
    .cmp  (cmp)
  );

  assign req_stall = (state != StIdle);

  always_comb begin
    ah_in     = {(9'(req.length_words) + 9'd2), 2'b00};
    too_short = req.is_esp ? (req.packet_length < ipsa_pkg::EspMinLen)
                           : (req.packet_length < ipsa_pkg::AhMinLen);
    malformed = !req.is_esp &&
                ((ah_in < ipsa_pkg::AhMinSize) || (16'(ah_in) > req.packet_length));
    start_res = '0;
    if (req.mode == ipsa_pkg::ModeCheck) begin
      if (too_short) begin
        start_res.verdict = ipsa_pkg::VerdictShort;
      end else if (malformed) begin
        start_res.verdict = ipsa_pkg::VerdictMalformed;
      end
    end
  end

  assign hit_now = ((item.mode == ipsa_pkg::ModeCheck) && cmp.pair_eq) ||
                   ((item.mode == ipsa_pkg::ModeRemove) && cmp.spi_eq);

  assign pass_offset = item.is_esp ? 11'd0 : ah_size;

  always_comb begin
    wr      = '0;
    wr.peer = item.peer_address;
    wr.spi  = item.spi;
    wr.seq  = item.seq_number;
    upd_res = '0;
    if (state == StUpd) begin
      case (item.mode)
        ipsa_pkg::ModeAdd: begin
          if (free_found) begin
            wr.key_we           = 1'b1;
            wr.seq_we           = 1'b1;
            wr.set_valid        = 1'b1;
            wr.seq              = '0;
            wr.addr             = free_slot;
            upd_res.entry_index = 4'(free_slot);
            upd_res.entry_valid = 1'b1;
          end else begin
            upd_res.verdict = ipsa_pkg::VerdictFull;
          end
        end
        ipsa_pkg::ModeRemove: begin
          if (hit) begin
            wr.clr_valid        = 1'b1;
            wr.addr             = ptr;
            upd_res.entry_index = 4'(ptr);
            upd_res.entry_valid = 1'b1;
          end
        end
        ipsa_pkg::ModeCheck: begin
          if (hit) begin
            upd_res.entry_index = 4'(ptr);
            upd_res.entry_valid = 1'b1;
            if (cmp.replay) begin
              upd_res.verdict = ipsa_pkg::VerdictReplay;
            end else begin
              wr.seq_we            = 1'b1;
              wr.addr              = ptr;
              upd_res.inner_offset = pass_offset;
            end
          end else if (free_found) begin
            wr.key_we            = 1'b1;
            wr.seq_we            = 1'b1;
            wr.set_valid         = 1'b1;
            wr.addr              = free_slot;
            upd_res.entry_index  = 4'(free_slot);
            upd_res.entry_valid  = 1'b1;
            upd_res.learned      = 1'b1;
            upd_res.inner_offset = pass_offset;
          end else begin
            upd_res.verdict      = ipsa_pkg::VerdictFull;
            upd_res.inner_offset = pass_offset;
          end
        end
        default: begin
          upd_res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      rsp_valid <= 1'b0;
    end else begin
      if (state == StDone && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (req_valid) begin
            case (req.mode)
              ipsa_pkg::ModeCheck: begin
                state <= (too_short || malformed) ? StDone : StRead;
              end
              ipsa_pkg::ModeAdd:    state <= StRead;
              ipsa_pkg::ModeRemove: state <= StRead;
              default:              state <= StDone;
            endcase
          end
        end
        StRead: state <= StCmp;
        StCmp: begin
          if (hit_now || (item.mode == ipsa_pkg::ModeAdd && !rd.valid) ||
              ptr == ipsa_pkg::LastSlot) begin
            state <= StUpd;
          end else begin
            state <= StRead;
          end
        end
        StUpd: state <= StDone;
        StDone: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      StIdle: begin
        if (req_valid) begin
          item       <= req;
          ah_size    <= ah_in;
          ptr        <= '0;
          free_found <= 1'b0;
          hit        <= 1'b0;
          res        <= start_res;
        end
      end
      StCmp: begin
        if (hit_now) begin
          hit <= 1'b1;
        end else begin
          if (!rd.valid && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= ptr;
          end
          if (!(item.mode == ipsa_pkg::ModeAdd && !rd.valid) &&
              ptr != ipsa_pkg::LastSlot) begin
            ptr <= ptr + 1'b1;
          end
        end
      end
      StUpd: res <= upd_res;
      StDone: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp <= res;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_cmp_after_read: assert property (@(posedge clk) disable iff (rst)
    state == StCmp |-> $past(state) == StRead)
    else $error("compare without a preceding slot read");

  a_write_in_update: assert property (@(posedge clk) disable iff (rst)
    (wr.key_we || wr.seq_we || wr.set_valid || wr.clr_valid) |-> state == StUpd)
    else $error("slot store written outside the update step");

  a_learned_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.learned |->
      rsp.entry_valid && rsp.verdict == ipsa_pkg::VerdictOk)
    else $error("learned response without an accepted entry");

  a_offset_verdict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.inner_offset != 11'd0 |->
      (rsp.verdict == ipsa_pkg::VerdictOk || rsp.verdict == ipsa_pkg::VerdictFull))
    else $error("inner offset on a rejected packet");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: SA table with learning and anti-replay check
// A queue of commands feeds a clocked driver. A clocked monitor predicts each
// accepted transaction against a local copy of the slot table and checks every
// response field in order. Directed corner cases come first, then random
// traffic over a small pool of security associations. Random idle and stall
// bursts are applied on both sides, with one long response hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] ModeSpare   = 2'd3;
  localparam int         PoolSize    = 24;
  localparam int         BurstAdds   = 18;
  localparam int         RandomItems = 400;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  ipsa_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  ipsa_pkg::rsp_t rsp;

  ipsa_pkg::req_t pending [$];
  ipsa_pkg::rsp_t sa_expect [$];

  logic        sa_live [ipsa_pkg::SaEntries];
  logic [31:0] sa_peer [ipsa_pkg::SaEntries];
  logic [31:0] sa_spi  [ipsa_pkg::SaEntries];
  logic [31:0] sa_seq  [ipsa_pkg::SaEntries];

  logic req_taken = 1'b0;
  logic calm      = 1'b0;
  logic hold_off  = 1'b0;
  int   req_gap   = 0;
  int   rsp_gap   = 0;
  int   accept_count = 0;
  int   rsp_count    = 0;
  int   error_count  = 0;
  int   learn_count  = 0;
  int   replay_count = 0;
  int   full_count   = 0;
  int   reject_count = 0;
  ipsa_pkg::rsp_t predicted;
  ipsa_pkg::rsp_t oldest;

  ipsec_sa_table_replay_check_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  task automatic queue_cmd(input logic [1:0] mode, input logic [31:0] peer,
                           input logic [31:0] spi, input logic [31:0] seq,
                           input logic esp, input logic [7:0] words,
                           input logic [15:0] plen);
    ipsa_pkg::req_t c;
    c.mode          = mode;
    c.peer_address  = peer;
    c.spi           = spi;
    c.seq_number    = seq;
    c.is_esp        = esp;
    c.length_words  = words;
    c.packet_length = plen;
    pending.push_back(c);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic int sa_claim(input logic [31:0] peer, input logic [31:0] spi);
    int slot;
    slot = -1;
    for (int i = 0; i < ipsa_pkg::SaEntries && slot < 0; i++)
      if (!sa_live[i]) slot = i;
    if (slot >= 0) begin
      sa_live[slot] = 1'b1;
      sa_peer[slot] = peer;
      sa_spi[slot]  = spi;
      sa_seq[slot]  = '0;
    end
    return slot;
  endfunction

  function automatic ipsa_pkg::rsp_t sa_predict(input ipsa_pkg::req_t c);
    ipsa_pkg::rsp_t r;
    int             slot;
    logic [10:0]    ah_size;
    logic           short_pkt;
    r         = '0;
    slot      = -1;
    ah_size   = ({3'b000, c.length_words} + 11'd2) << 2;
    short_pkt = c.is_esp ? (c.packet_length < ipsa_pkg::EspMinLen)
                         : (c.packet_length < ipsa_pkg::AhMinLen);
    case (c.mode)
      ipsa_pkg::ModeAdd: begin
        slot = sa_claim(c.peer_address, c.spi);
        if (slot < 0) r.verdict = ipsa_pkg::VerdictFull;
      end
      ipsa_pkg::ModeRemove: begin
        for (int i = 0; i < ipsa_pkg::SaEntries && slot < 0; i++)
          if (sa_live[i] && sa_spi[i] == c.spi) slot = i;
        if (slot >= 0) sa_live[slot] = 1'b0;
      end
      ipsa_pkg::ModeCheck: begin
        if (short_pkt) begin
          r.verdict = ipsa_pkg::VerdictShort;
        end else if (!c.is_esp && (ah_size < ipsa_pkg::AhMinSize ||
                                   {5'b00000, ah_size} > c.packet_length)) begin
          r.verdict = ipsa_pkg::VerdictMalformed;
        end else begin
          for (int i = 0; i < ipsa_pkg::SaEntries && slot < 0; i++)
            if (sa_live[i] && sa_spi[i] == c.spi && sa_peer[i] == c.peer_address) slot = i;
          if (slot < 0) begin
            slot      = sa_claim(c.peer_address, c.spi);
            r.learned = (slot >= 0);
          end
          if (slot < 0) begin
            r.verdict      = ipsa_pkg::VerdictFull;
            r.inner_offset = c.is_esp ? 11'd0 : ah_size;
          end else if (c.seq_number <= sa_seq[slot] && sa_seq[slot] != '0) begin
            r.verdict = ipsa_pkg::VerdictReplay;
          end else begin
            sa_seq[slot]   = c.seq_number;
            r.inner_offset = c.is_esp ? 11'd0 : ah_size;
          end
        end
      end
      default: ;
    endcase
    if (slot >= 0) begin
      r.entry_index = slot[3:0];
      r.entry_valid = 1'b1;
    end
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_taken)) begin
      if (req_gap > 0) begin
        req_gap   <= req_gap - 1;
        req_valid <= 1'b0;
      end else if (pending.size() == 0) begin
        req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        req_gap   <= $urandom_range(0, 2);
        req_valid <= 1'b0;
      end else begin
        req       <= pending.pop_front();
        req_valid <= 1'b1;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_off) begin
      rsp_stall <= 1'b1;
    end else if (rsp_gap > 0) begin
      rsp_gap   <= rsp_gap - 1;
      rsp_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rsp_gap   <= $urandom_range(0, 2);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // hold responses off for a long stretch while commands keep coming
  initial begin
    wait (accept_count >= 150);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (80) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      req_taken = req_valid && !req_stall;
      if (req_taken) begin
        predicted = sa_predict(req);
        sa_expect.push_back(predicted);
        accept_count++;
        if (predicted.learned) learn_count++;
        if (predicted.verdict == ipsa_pkg::VerdictReplay) replay_count++;
        if (predicted.verdict == ipsa_pkg::VerdictFull) full_count++;
        if (predicted.verdict == ipsa_pkg::VerdictShort ||
            predicted.verdict == ipsa_pkg::VerdictMalformed)
          reject_count++;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_count++;
        if (sa_expect.size() == 0) begin
          report_mismatch("response with no command pending", 32'(rsp), '0);
        end else begin
          oldest = sa_expect.pop_front();
          if (rsp.verdict !== oldest.verdict)
            report_mismatch("verdict", 32'(rsp.verdict), 32'(oldest.verdict));
          if (rsp.entry_index !== oldest.entry_index)
            report_mismatch("entry_index", 32'(rsp.entry_index), 32'(oldest.entry_index));
          if (rsp.entry_valid !== oldest.entry_valid)
            report_mismatch("entry_valid", 32'(rsp.entry_valid), 32'(oldest.entry_valid));
          if (rsp.learned !== oldest.learned)
            report_mismatch("learned", 32'(rsp.learned), 32'(oldest.learned));
          if (rsp.inner_offset !== oldest.inner_offset)
            report_mismatch("inner_offset", 32'(rsp.inner_offset), 32'(oldest.inner_offset));
        end
      end
    end
    calm = (pending.size() < 40) || (accept_count % 64 < 16);
  end

  initial begin : stimulus
    logic [31:0] pool_peer [PoolSize];
    logic [31:0] pool_spi  [PoolSize];
    logic [31:0] pool_seq  [PoolSize];
    logic [31:0] burst_spi [BurstAdds];
    logic [31:0] seq;
    logic [7:0]  words;
    logic        esp;
    int          p;
    int          k;
    int          total;
    bit          burst_done;

    for (int i = 0; i < ipsa_pkg::SaEntries; i++) sa_live[i] = 1'b0;
    for (int i = 0; i < PoolSize; i++) begin
      pool_peer[i] = $urandom;
      pool_spi[i]  = (i % 6 == 5) ? pool_spi[i - 1] : $urandom;
      pool_seq[i]  = $urandom_range(0, 1000);
    end

    queue_cmd(ipsa_pkg::ModeAdd, '0, '0, '0, 1'b0, 8'd0, 16'd0);
    queue_cmd(ipsa_pkg::ModeAdd, '1, '1, '1, 1'b1, 8'hff, 16'hffff);
    queue_cmd(ipsa_pkg::ModeCheck, '0, '0, 32'd9, 1'b1, 8'd0, 16'd7);
    queue_cmd(ipsa_pkg::ModeCheck, '0, '0, '0, 1'b1, 8'd0, 16'd8);
    queue_cmd(ipsa_pkg::ModeCheck, '0, '0, '0, 1'b1, 8'd0, 16'd8);
    queue_cmd(ipsa_pkg::ModeCheck, '0, '0, 32'd5, 1'b1, 8'hff, 16'd100);
    queue_cmd(ipsa_pkg::ModeCheck, '0, '0, 32'd5, 1'b1, 8'd0, 16'd100);
    queue_cmd(ipsa_pkg::ModeCheck, '0, '0, 32'd4, 1'b1, 8'd0, 16'd100);
    queue_cmd(ipsa_pkg::ModeCheck, '1, '1, 32'd1, 1'b0, 8'd1, 16'd11);
    queue_cmd(ipsa_pkg::ModeCheck, '1, '1, 32'd1, 1'b0, 8'd0, 16'd12);
    queue_cmd(ipsa_pkg::ModeCheck, '1, '1, '1, 1'b0, 8'd1, 16'd12);
    queue_cmd(ipsa_pkg::ModeCheck, '1, '1, '0, 1'b0, 8'd1, 16'd12);
    queue_cmd(ipsa_pkg::ModeCheck, 32'h0a000001, 32'h00001000, 32'd1, 1'b0, 8'hff, 16'hffff);
    queue_cmd(ipsa_pkg::ModeCheck, 32'h0a000001, 32'h00001000, 32'd2, 1'b0, 8'hff, 16'd1027);
    queue_cmd(ipsa_pkg::ModeRemove, 32'h12345678, '1, '0, 1'b0, 8'd0, 16'd0);
    queue_cmd(ipsa_pkg::ModeRemove, '0, 32'h12345678, '0, 1'b0, 8'd0, 16'd0);
    queue_cmd(ModeSpare, '1, '1, '1, 1'b1, 8'hff, 16'hffff);
    queue_cmd(ipsa_pkg::ModeCheck, 32'h0a000002, 32'h00001000, '1, 1'b1, 8'd0, 16'hffff);
    queue_cmd(ipsa_pkg::ModeRemove, '0, 32'h00001000, '0, 1'b0, 8'd0, 16'd0);
    queue_cmd(ipsa_pkg::ModeCheck, 32'h0a000002, 32'h00001000, '1, 1'b1, 8'd0, 16'd8);

    burst_done = 1'b0;
    total      = 0;
    while (total < RandomItems) begin
      if (!burst_done && total >= RandomItems / 2) begin
        // fill the table, probe it full, then drain it again
        burst_done = 1'b1;
        for (int i = 0; i < BurstAdds; i++) begin
          burst_spi[i] = $urandom;
          queue_cmd(ipsa_pkg::ModeAdd, $urandom, burst_spi[i], $urandom,
                    1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom));
        end
        queue_cmd(ipsa_pkg::ModeCheck, $urandom, $urandom, $urandom, 1'b0, 8'hff, 16'hffff);
        queue_cmd(ipsa_pkg::ModeCheck, $urandom, $urandom, $urandom, 1'b1, 8'($urandom),
                  16'd8);
        for (int i = 0; i < BurstAdds; i++)
          queue_cmd(ipsa_pkg::ModeRemove, $urandom, burst_spi[i], $urandom,
                    1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom));
        total += 2 * BurstAdds + 2;
      end
      p   = $urandom_range(0, PoolSize - 1);
      k   = $urandom_range(0, 99);
      esp = 1'($urandom_range(0, 1));
      if (k < 50) begin
        case ($urandom_range(0, 9))
          0, 1: seq = pool_seq[p] - $urandom_range(0, 3);
          2: seq = $urandom_range(0, 1) ? 32'd0 : $urandom;
          default: begin
            pool_seq[p] = pool_seq[p] + $urandom_range(1, 200);
            seq         = pool_seq[p];
          end
        endcase
        words = ($urandom_range(0, 15) == 0) ? 8'hff : 8'($urandom_range(1, 20));
        if (esp)
          queue_cmd(ipsa_pkg::ModeCheck, pool_peer[p], pool_spi[p], seq, 1'b1,
                    8'($urandom), 16'($urandom_range(8, 1500)));
        else
          queue_cmd(ipsa_pkg::ModeCheck, pool_peer[p], pool_spi[p], seq, 1'b0, words,
                    16'((words + 2) * 4 + $urandom_range(0, 64)));
      end else if (k < 55) begin
        words = 8'($urandom_range(1, 255));
        queue_cmd(ipsa_pkg::ModeCheck, $urandom, $urandom, $urandom, esp, words,
                  16'((words + 2) * 4 + $urandom_range(0, 64)));
      end else if (k < 67) begin
        queue_cmd(ipsa_pkg::ModeCheck, pool_peer[p], pool_spi[p], $urandom, esp,
                  8'($urandom),
                  16'($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom));
      end else if (k < 75) begin
        if ($urandom_range(0, 2) == 0)
          queue_cmd(ipsa_pkg::ModeAdd, $urandom, $urandom, $urandom, esp, 8'($urandom),
                    16'($urandom));
        else
          queue_cmd(ipsa_pkg::ModeAdd, pool_peer[p], pool_spi[p], $urandom, esp,
                    8'($urandom), 16'($urandom));
      end else if (k < 93) begin
        queue_cmd(ipsa_pkg::ModeRemove, $urandom,
                  ($urandom_range(0, 4) == 0) ? $urandom : pool_spi[p],
                  $urandom, esp, 8'($urandom), 16'($urandom));
      end else if (k < 96) begin
        queue_cmd(ModeSpare, $urandom, $urandom, $urandom, esp, 8'($urandom), 16'($urandom));
      end else begin
        queue_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, esp, 8'($urandom),
                  16'($urandom));
      end
      total++;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || req_valid || sa_expect.size() != 0) @(negedge clk);
    repeat (2 * ipsa_pkg::SaEntries + 8) @(posedge clk);

    $display("Run covered %0d commands and %0d responses: %0d learned, %0d replays,",
             accept_count, rsp_count, learn_count, replay_count);
    $display("%0d table-full verdicts, %0d length rejects, %0d mismatches.",
             full_count, reject_count, error_count);
    if (error_count == 0) begin
      $display("** ipsec_sa_table_replay_check_core: PASSED **");
    end else begin
      $display("** ipsec_sa_table_replay_check_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d responses still outstanding", sa_expect.size());
    $display("** ipsec_sa_table_replay_check_core: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ipsa_pkg.sv
hw/rtl/ipsa_slot_store.sv
hw/rtl/ipsa_match_unit.sv
hw/rtl/ipsec_sa_table_replay_check_core.sv
tb/testbench.sv
